/* rtl/hsv_pkg.sv */
package hsv_pkg;

	localparam logic [8:0] HUE_GREEN  = 9'd120;
	localparam logic [8:0] HUE_BLUE   = 9'd240;
	localparam logic [8:0] HUE_FULL   = 9'd360;
	localparam logic [8:0] HUE_SEXT1  = 9'd60;
	localparam logic [8:0] HUE_SEXT3  = 9'd180;
	localparam logic [8:0] HUE_SEXT5  = 9'd300;
	localparam logic [7:0] VAL_MAX    = 8'd255;
	// 2^20 / 60 rounded up; exact floor for products below 2^14
	localparam logic [14:0] RECIP_60  = 15'd17477;

	typedef enum logic [1:0] {
		MAX_RED,
		MAX_GREEN,
		MAX_BLUE
	} max_sel_t;

	typedef enum logic [2:0] {
		SEXT_0,
		SEXT_1,
		SEXT_2,
		SEXT_3,
		SEXT_4,
		SEXT_5
	} sextant_t;

	localparam logic OP_LIGHTEN = 1'b0;

	// data that rides alongside the dividers
	typedef struct packed {
		logic        opcode;
		logic [7:0]  mx;
		logic        neg;
		max_sel_t    msel;
		logic        grey;
		logic        fzero;
		logic [15:0] lprod;
	} side_t;

endpackage

/* rtl/hsv_div.sv */
module hsv_div #(
	parameter int NW   = 16,
	parameter int DW   = 16,
	parameter int STEP = 4
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [NW-1:0] quo
);

	localparam int NS = NW / STEP;

	logic [DW:0]   rem_s [1:NS-1];
	logic [NW-1:0] nq_s  [1:NS];
	logic [DW-1:0] den_s [1:NS-1];

	// restoring division, STEP quotient bits per stage
	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic [DW:0]   r_in, r_c;
		logic [NW-1:0] n_in, n_c;
		logic [DW-1:0] d_in;

		if (k == 0) begin : g_first
			assign r_in = '0;
			assign n_in = num;
			assign d_in = den;
		end else begin : g_next
			assign r_in = rem_s[k];
			assign n_in = nq_s[k];
			assign d_in = den_s[k];
		end

		always_comb begin
			r_c = r_in;
			n_c = n_in;
			for (int i = 0; i < STEP; i++) begin
				r_c = {r_c[DW-1:0], n_c[NW-1]};
				n_c = {n_c[NW-2:0], 1'b0};
				if (r_c >= {1'b0, d_in}) begin
					r_c = r_c - {1'b0, d_in};
					n_c[0] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				nq_s[k+1] <= n_c;
			end
		end

		if (k < NS - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1] <= r_c;
					den_s[k+1] <= d_in;
				end
			end
		end
	end

	assign quo = nq_s[NS];

endmodule

/* rtl/hsv_rebuild.sv */
module hsv_rebuild (
	input  logic       clk,
	input  logic       en,
	input  logic [8:0] hue,
	input  logic [7:0] sat,
	input  logic [7:0] val,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue
);
	import hsv_pkg::*;

	logic [15:0] p_s8;
	logic [8:0]  h_s8;
	logic [7:0]  hi_s8;
	logic [16:0] qsum;
	logic [7:0]  q255;
	sextant_t    sx_c;
	logic [8:0]  xr_c;
	logic [7:0]  lo_s9, e_s9, hi_s9;
	logic [5:0]  xr_s9;
	sextant_t    sx_s9;
	logic [13:0] m_s10;
	logic [7:0]  lo_s10, hi_s10;
	sextant_t    sx_s10;
	logic [28:0] t_c;
	logic [7:0]  rp_c;

	// chroma product
	always_ff @(posedge clk) begin
		if (en) begin
			p_s8  <= val * sat;
			h_s8  <= hue;
			hi_s8 <= val;
		end
	end

	// divide by 255 and pick the sextant
	assign qsum = {1'b0, p_s8} + {9'd0, p_s8[15:8]} + 17'd1;
	assign q255 = qsum[15:8];

	always_comb begin
		if (h_s8 < HUE_SEXT1) begin
			sx_c = SEXT_0; xr_c = h_s8;
		end else if (h_s8 < HUE_GREEN) begin
			sx_c = SEXT_1; xr_c = HUE_GREEN - h_s8;
		end else if (h_s8 < HUE_SEXT3) begin
			sx_c = SEXT_2; xr_c = h_s8 - HUE_GREEN;
		end else if (h_s8 < HUE_BLUE) begin
			sx_c = SEXT_3; xr_c = HUE_BLUE - h_s8;
		end else if (h_s8 < HUE_SEXT5) begin
			sx_c = SEXT_4; xr_c = h_s8 - HUE_BLUE;
		end else begin
			sx_c = SEXT_5; xr_c = HUE_FULL - h_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s9 <= hi_s8 - q255;
			e_s9  <= q255;
			hi_s9 <= hi_s8;
			xr_s9 <= xr_c[5:0];
			sx_s9 <= sx_c;
		end
	end

	// ramp product
	always_ff @(posedge clk) begin
		if (en) begin
			m_s10  <= xr_s9 * e_s9;
			lo_s10 <= lo_s9;
			hi_s10 <= hi_s9;
			sx_s10 <= sx_s9;
		end
	end

	// divide by 60 through the reciprocal, then place the channels
	assign t_c  = m_s10 * RECIP_60;
	assign rp_c = t_c[27:20] + lo_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			case (sx_s10)
				SEXT_0: begin red <= hi_s10; green <= rp_c; blue <= lo_s10; end
				SEXT_1: begin red <= rp_c; green <= hi_s10; blue <= lo_s10; end
				SEXT_2: begin red <= lo_s10; green <= hi_s10; blue <= rp_c; end
				SEXT_3: begin red <= lo_s10; green <= rp_c; blue <= hi_s10; end
				SEXT_4: begin red <= rp_c; green <= lo_s10; blue <= hi_s10; end
				default: begin red <= hi_s10; green <= lo_s10; blue <= rp_c; end
			endcase
		end
	end

endmodule

/* rtl/hsv_value_scale.sv */
// Channel  Direction  tdata                                tuser
// s_axis   in         red, green, blue, scale_factor (40)  opcode
// m_axis   out        red, green, blue (24)                -
//
// One pixel enters per cycle unless a held result stalls the pipe. The depth is set by the
// three 16-bit restoring dividers (four stages of four bits each).
// arst_n clears the stage valid bits only.
// A held result stalls every stage together; nothing is lost or repeated.
module hsv_value_scale (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // in_red, in_green, in_blue, scale_factor
	input  logic        s_axis_tuser,  // opcode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata   // out_red, out_green, out_blue
);
	import hsv_pkg::*;

	localparam int NSTG = 11;

	logic            en;
	logic [NSTG:1]   vld_q;
	logic            op_s1;
	logic [7:0]      r_s1, g_s1, b_s1;
	logic [15:0]     f_s1;
	logic [7:0]      mx_c, mn_c, d_c;
	max_sel_t        ms_c;
	logic [8:0]      df_c;
	logic [7:0]      ad_c;
	logic [23:0]     lp_c;
	side_t           sb_s [2:6];
	logic [15:0]     hnum_s2, snum_s2, dnum_s2;
	logic [7:0]      hden_s2, sden_s2;
	logic [15:0]     dden_s2;
	logic [15:0]     hq, sq, dq;
	logic [8:0]      h_c;
	logic [7:0]      s_c, v_c;
	logic [15:0]     v16_c, exc_c;
	logic [8:0]      h_s7;
	logic [7:0]      s_s7, v_s7;
	logic [7:0]      ro, go, bo;

	assign en            = !vld_q[NSTG] || m_axis_tready;
	assign s_axis_tready = en;

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NSTG-1:1], s_axis_tvalid};
		end
	end

	// capture the transaction
	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= s_axis_tuser;
			r_s1  <= s_axis_tdata[7:0];
			g_s1  <= s_axis_tdata[15:8];
			b_s1  <= s_axis_tdata[23:16];
			f_s1  <= s_axis_tdata[39:24];
		end
	end

	// max, min and hue difference
	always_comb begin
		mx_c = r_s1;
		mn_c = r_s1;
		if (g_s1 > mx_c) mx_c = g_s1;
		if (b_s1 > mx_c) mx_c = b_s1;
		if (g_s1 < mn_c) mn_c = g_s1;
		if (b_s1 < mn_c) mn_c = b_s1;
		d_c = mx_c - mn_c;
		if (mx_c == r_s1) begin
			ms_c = MAX_RED;   df_c = {1'b0, g_s1} - {1'b0, b_s1};
		end else if (mx_c == g_s1) begin
			ms_c = MAX_GREEN; df_c = {1'b0, b_s1} - {1'b0, r_s1};
		end else begin
			ms_c = MAX_BLUE;  df_c = {1'b0, r_s1} - {1'b0, g_s1};
		end
		ad_c = df_c[8] ? 8'(-df_c) : df_c[7:0];
		lp_c = mx_c * f_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s[2].opcode <= op_s1;
			sb_s[2].mx     <= mx_c;
			sb_s[2].neg    <= df_c[8];
			sb_s[2].msel   <= ms_c;
			sb_s[2].grey   <= (d_c == 8'd0);
			sb_s[2].fzero  <= (f_s1 == 16'd0);
			sb_s[2].lprod  <= lp_c[23:8];
			hnum_s2 <= 16'd60 * {8'd0, ad_c};
			hden_s2 <= d_c;
			snum_s2 <= {8'd0, VAL_MAX} * {8'd0, d_c};
			sden_s2 <= mx_c;
			dnum_s2 <= {mx_c, 8'd0};
			dden_s2 <= f_s1;
		end
	end

	// hold side data level with the dividers
	for (genvar k = 3; k <= 6; k++) begin : g_side
		always_ff @(posedge clk) begin
			if (en) begin
				sb_s[k] <= sb_s[k-1];
			end
		end
	end

	hsv_div #(.NW(16), .DW(8), .STEP(4)) u_hue_div (
		.clk(clk), .en(en), .num(hnum_s2), .den(hden_s2), .quo(hq)
	);

	hsv_div #(.NW(16), .DW(8), .STEP(4)) u_sat_div (
		.clk(clk), .en(en), .num(snum_s2), .den(sden_s2), .quo(sq)
	);

	hsv_div #(.NW(16), .DW(16), .STEP(4)) u_dark_div (
		.clk(clk), .en(en), .num(dnum_s2), .den(dden_s2), .quo(dq)
	);

	// finish hue, scale value, clamp overshoot
	always_comb begin
		if (sb_s[6].grey) begin
			h_c = 9'd0;
		end else begin
			case (sb_s[6].msel)
				MAX_RED:   h_c = sb_s[6].neg ? ((hq[5:0] == 6'd0) ? 9'd0
				                 : HUE_FULL - {3'd0, hq[5:0]}) : {3'd0, hq[5:0]};
				MAX_GREEN: h_c = sb_s[6].neg ? HUE_GREEN - {3'd0, hq[5:0]}
				                 : HUE_GREEN + {3'd0, hq[5:0]};
				default:   h_c = sb_s[6].neg ? HUE_BLUE - {3'd0, hq[5:0]}
				                 : HUE_BLUE + {3'd0, hq[5:0]};
			endcase
		end
		s_c = (sb_s[6].mx == 8'd0) ? 8'd0 : sq[7:0];
		if (sb_s[6].opcode == OP_LIGHTEN) begin
			v16_c = sb_s[6].lprod;
		end else if (sb_s[6].fzero) begin
			v16_c = (sb_s[6].mx != 8'd0) ? 16'hFFFF : 16'd0;
		end else begin
			v16_c = dq;
		end
		exc_c = v16_c - {8'd0, VAL_MAX};
		if (v16_c > {8'd0, VAL_MAX}) begin
			v_c = VAL_MAX;
			s_c = ({8'd0, s_c} > exc_c) ? s_c - exc_c[7:0] : 8'd0;
		end else begin
			v_c = v16_c[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h_s7 <= h_c;
			s_s7 <= s_c;
			v_s7 <= v_c;
		end
	end

	hsv_rebuild u_rebuild (
		.clk(clk), .en(en), .hue(h_s7), .sat(s_s7), .val(v_s7),
		.red(ro), .green(go), .blue(bo)
	);

	assign m_axis_tvalid = vld_q[NSTG];
	assign m_axis_tdata  = {bo, go, ro};

`ifndef NO_ASSERTIONS
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[7] |-> (h_s7 < HUE_FULL))
		else $error("hue out of range");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(h_s7) && $stable(v_s7) && $stable(vld_q))
		else $error("pipeline moved during stall");

	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[7] && (v_s7 != VAL_MAX) |-> (s_s7 <= VAL_MAX))
		else $error("saturation invalid");
`endif

endmodule

/* tb/hsv_value_scale_tb.sv */
`timescale 1ns / 1ps

module hsv_value_scale_tb;
	import hsv_pkg::*;

	localparam int LATENCY     = 11;
	localparam int STALL_LIMIT = 5000;
	localparam int N_RANDOM    = 1100;

	typedef struct packed {
		logic        opcode;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [15:0] factor;
	} pixel_req_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;  // in_red, in_green, in_blue, scale_factor
	logic        s_axis_tuser;  // opcode
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;  // out_red, out_green, out_blue

	pixel_req_t pending_px[$];
	pixel_t     expected_px[$];
	int         n_errors;
	bit         quiet_phase;
	bit         hold_sink;
	bit         pause_src;
	bit         in_taken;
	int         idle_cycles;

	hsv_value_scale u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] ramp_chan(int unsigned x, int unsigned e, int unsigned lo);
		return 8'((x * e) / 60 + lo);
	endfunction

	// Brightness adjustment through an integer HSV round trip
	function automatic pixel_t adjust_pixel(pixel_req_t p);
		int unsigned r, g, b, mx, mn, d, s, v, hi, lo, e, excess;
		int          h;
		pixel_t      o;
		r = p.red; g = p.green; b = p.blue;
		mx = r; mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		d = mx - mn;
		h = 0;
		if (d != 0) begin
			if (mx == r) h = (60 * (int'(g) - int'(b))) / int'(d);
			else if (mx == g) h = (60 * (int'(b) - int'(r))) / int'(d) + 120;
			else h = (60 * (int'(r) - int'(g))) / int'(d) + 240;
			if (h < 0) h += 360;
		end
		s = (mx != 0) ? (255 * d) / mx : 0;
		if (p.opcode == OP_LIGHTEN) v = (mx * p.factor) >> 8;
		else if (p.factor != 0) v = (mx << 8) / p.factor;
		else v = (mx != 0) ? 65535 : 0;
		if (v > 255) begin
			excess = v - 255;
			s = (s > excess) ? s - excess : 0;
			v = 255;
		end
		hi = v;
		lo = hi - (hi * s) / 255;
		e = hi - lo;
		if (h < 60) o = '{8'(hi), ramp_chan(h, e, lo), 8'(lo)};
		else if (h < 120) o = '{ramp_chan(120 - h, e, lo), 8'(hi), 8'(lo)};
		else if (h < 180) o = '{8'(lo), 8'(hi), ramp_chan(h - 120, e, lo)};
		else if (h < 240) o = '{8'(lo), ramp_chan(240 - h, e, lo), 8'(hi)};
		else if (h < 300) o = '{ramp_chan(h - 240, e, lo), 8'(lo), 8'(hi)};
		else o = '{8'(hi), 8'(lo), ramp_chan(360 - h, e, lo)};
		return o;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
		n_errors++;
	endtask

	task automatic queue_pixel(bit op, int r, int g, int b, int f);
		pending_px.push_back('{op, 8'(r), 8'(g), 8'(b), 16'(f)});
	endtask

	// Note whether the input side took a transaction at this edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) in_taken <= 1'b0;
		else in_taken <= s_axis_tvalid && s_axis_tready;
	end

	// Drive the next pending pixel; idle at random outside quiet phases
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= 1'b0;
		end else begin
			if (in_taken) void'(pending_px.pop_front());
			if (!s_axis_tvalid || in_taken) begin
				if (pending_px.size() > 0 && !pause_src &&
				    (quiet_phase || $urandom_range(99) >= 9)) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {pending_px[0].factor, pending_px[0].blue,
					                  pending_px[0].green, pending_px[0].red};
					s_axis_tuser  <= pending_px[0].opcode;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Stall the result side at random, or hold off entirely on request
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) m_axis_tready <= 1'b0;
		else m_axis_tready <= !hold_sink && (quiet_phase || $urandom_range(99) >= 9);
	end

	// Predict each accepted pixel and check each accepted result
	always @(posedge clk) begin
		pixel_t     got, want;
		pixel_req_t req;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				req = '{s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8],
				        s_axis_tdata[23:16], s_axis_tdata[39:24]};
				expected_px.push_back(adjust_pixel(req));
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16]};
				if (expected_px.size() == 0) begin
					report_mismatch("unexpected result, red", got.red, 0);
				end else begin
					want = expected_px.pop_front();
					if (got.red !== want.red) report_mismatch("red", got.red, want.red);
					if (got.green !== want.green) report_mismatch("green", got.green, want.green);
					if (got.blue !== want.blue) report_mismatch("blue", got.blue, want.blue);
				end
			end
		end
	end

	// Watchdog: end the run after a long spell with no transaction
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		int k;
		n_errors = 0; quiet_phase = 0; hold_sink = 0; pause_src = 0;
		idle_cycles = 0;
		s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = 1'b0; m_axis_tready = 1'b0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Directed: extremes, both opcodes, black, grey, zero factor, overshoot
		queue_pixel(0, 0, 0, 0, 0);
		queue_pixel(1, 0, 0, 0, 0);
		queue_pixel(1, 200, 30, 90, 0);
		queue_pixel(0, 255, 255, 255, 65535);
		queue_pixel(1, 255, 255, 255, 65535);
		queue_pixel(0, 128, 128, 128, 256);
		queue_pixel(0, 255, 0, 0, 256);
		queue_pixel(0, 255, 255, 0, 256);
		queue_pixel(0, 0, 255, 0, 256);
		queue_pixel(0, 0, 255, 255, 256);
		queue_pixel(0, 0, 0, 255, 256);
		queue_pixel(0, 255, 0, 255, 256);
		queue_pixel(0, 200, 100, 50, 512);
		queue_pixel(0, 200, 150, 140, 300);
		queue_pixel(1, 40, 200, 120, 128);
		queue_pixel(1, 10, 60, 250, 1);
		queue_pixel(1, 250, 20, 100, 65535);
		queue_pixel(0, 250, 240, 10, 1);
		queue_pixel(0, 90, 20, 200, 43690);
		queue_pixel(1, 170, 85, 85, 21845);

		// Fill the pipe while the result side holds off
		for (k = 0; k < 40; k++)
			queue_pixel($urandom_range(1), $urandom_range(255), $urandom_range(255),
			             $urandom_range(255), $urandom_range(65535));
		hold_sink = 1;
		repeat (200) @(posedge clk);
		hold_sink = 0;

		// Pause the sender until every result is home
		while (pending_px.size() != 0) @(posedge clk);
		pause_src = 1;
		while (expected_px.size() != 0) @(posedge clk);
		pause_src = 0;

		// Random pixels, a quarter of them with near-unity factors, with a quiet stretch
		for (k = 0; k < N_RANDOM; k++) begin
			int f;
			case ($urandom_range(3))
				0: f = $urandom_range(65535);
				1: f = $urandom_range(1023);
				2: f = $urandom_range(255, 320);
				default: f = $urandom_range(1) ? 0 : $urandom_range(3);
			endcase
			queue_pixel($urandom_range(1), $urandom_range(255), $urandom_range(255),
			             $urandom_range(255), f);
		end
		while (pending_px.size() >= N_RANDOM / 2) @(posedge clk);
		quiet_phase = 1;
		while (pending_px.size() >= N_RANDOM / 4) @(posedge clk);
		quiet_phase = 0;

		while (pending_px.size() != 0) @(posedge clk);
		while (expected_px.size() != 0) @(posedge clk);
		repeat (LATENCY * 3) @(posedge clk);
		if (n_errors == 0 && expected_px.size() == 0 && !m_axis_tvalid)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* files.f */
rtl/hsv_pkg.sv
rtl/hsv_div.sv
rtl/hsv_rebuild.sv
rtl/hsv_value_scale.sv
tb/hsv_value_scale_tb.sv
